// File: hdl/assert_macros.svh
// Assertion macros used by the RTL of the position counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BQPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define BQPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BQPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BQPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/bqpc_pkg.sv
// Types, constants and the quadrature step function of the position counter.
`timescale 1ns / 1ps
`default_nettype none
package bqpc_pkg;
    localparam int CountW = 25;
    localparam int PosW = 16;
    localparam int StepW = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;
    localparam int DivCntW = $clog2(CountW);
    localparam int MulCntW = $clog2(StepW);
    localparam logic [1:0] AbMask = 2'h3;
    localparam logic [3:0] IndexMask = 4'hf;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_READ,
        KIND_LOAD,
        KIND_NONE
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        REG_STEPS,
        REG_MIN,
        REG_MAX,
        REG_WRAP,
        REG_ENABLE
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BOUND,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        d = 2'sd0;
        if (idx inside {4'd1, 4'd7, 4'd8, 4'd14}) begin
            d = -2'sd1;
        end else if (idx inside {4'd2, 4'd4, 4'd11, 4'd13}) begin
            d = 2'sd1;
        end
        return d;
    endfunction
endpackage
`default_nettype wire

// File: hdl/bqpc_channels.sv
// Handshake channel interfaces for items, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface bqpc_in_if import bqpc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic                   pin_a;
    logic                   pin_b;
    logic signed [PosW-1:0] new_value;
    modport source (output valid, kind, pin_a, pin_b, new_value, input ready);
    modport sink (input valid, kind, pin_a, pin_b, new_value, output ready);
endinterface

interface bqpc_out_if import bqpc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PosW-1:0] position;
    logic signed [PosW-1:0] change;
    modport source (output valid, position, change, input ready);
    modport sink (input valid, position, change, output ready);
endinterface

interface bqpc_cfg_if import bqpc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/bounded_quadrature_position_counter.sv
// Top level of the bounded quadrature position counter.
//
//  channel  direction  word contents
//  i_in     sink       kind, pin_a, pin_b, new_value
//  o_out    source     position, change
//  i_cfg    sink       index, data (register write, always ready)
//
// A new word is accepted only in the idle state, once the last word has finished.
// A bit-serial multiply forms the bounds and the scaled load value, then a bound
// step, a setup step and a restoring division by the steps per detent.
// The result sits in an output register; a stalled sink holds the finish step.
// Reset is synchronous and clears the count, the last reading and the control state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bounded_quadrature_position_counter import bqpc_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bqpc_in_if.sink     i_in,
    bqpc_out_if.source  o_out,
    bqpc_cfg_if.sink    i_cfg
);
    t_state r_state, n_state;

    logic [StepW-1:0]         r_steps;
    logic signed [PosW-1:0]   r_min, r_max;
    logic                     r_wrap, r_enable;

    logic [1:0]               r_prev_ab;
    logic signed [CountW-1:0] r_count, n_count;
    logic signed [PosW-1:0]   r_last;

    t_kind                    r_kind;
    logic [1:0]               r_ab;
    logic signed [PosW-1:0]   r_new;
    logic [StepW-1:0]         r_s, r_mbits;
    logic [MulCntW-1:0]       r_mul_cnt;
    logic signed [CountW-1:0] r_lo, r_hi, r_ld, n_lo, n_hi, n_ld;

    logic [DivCntW-1:0]       r_div_cnt;
    logic [StepW-1:0]         r_rem, n_rem;
    logic [CountW-1:0]        r_quo, n_quo;
    logic                     r_neg;

    logic                     r_out_valid;
    logic signed [PosW-1:0]   r_out_pos, r_out_chg;

    logic                     w_accept, w_apply, w_load_out;
    logic signed [1:0]        w_delta;
    logic signed [CountW:0]   w_cand, w_lo, w_hi, w_t1, w_t2;
    logic [StepW+1:0]         w_diff;
    logic                     w_ge;
    logic signed [PosW-1:0]   w_pos, w_chg;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.position = r_out_pos;
    assign o_out.change = r_out_chg;
    assign w_accept     = i_in.valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Serial multiply: one bit of the steps per cycle, most significant first.
    always_comb begin
        n_lo = {r_lo[CountW-2:0], 1'b0};
        n_hi = {r_hi[CountW-2:0], 1'b0};
        n_ld = {r_ld[CountW-2:0], 1'b0};
        if (r_mbits[StepW-1]) begin
            n_lo = n_lo + {{(CountW-PosW){r_min[PosW-1]}}, r_min};
            n_hi = n_hi + {{(CountW-PosW){r_max[PosW-1]}}, r_max};
            n_ld = n_ld + {{(CountW-PosW){r_new[PosW-1]}}, r_new};
        end
    end

    // Bound rule: the upper check first, then the lower one.
    always_comb begin
        w_lo = {r_lo[CountW-1], r_lo};
        w_hi = {r_hi[CountW-1], r_hi};
        w_apply = ((r_kind == KIND_SAMPLE) && r_enable) || (r_kind == KIND_LOAD);
        w_delta = quad_delta({r_prev_ab, r_ab} & IndexMask);
        if (r_kind == KIND_LOAD) begin
            w_cand = {r_ld[CountW-1], r_ld};
        end else begin
            w_cand = {r_count[CountW-1], r_count}
                + {{(CountW-1){w_delta[1]}}, w_delta};
        end
        w_t1 = (w_cand > w_hi) ? (r_wrap ? w_lo : w_hi) : w_cand;
        w_t2 = (w_t1 < w_lo) ? (r_wrap ? w_hi : w_lo) : w_t1;
        n_count = w_apply ? w_t2[CountW-1:0] : r_count;
    end

    // Restoring division step, one quotient bit per cycle.
    always_comb begin
        w_diff = {1'b0, r_rem, r_quo[CountW-1]} - {2'b00, r_s};
        w_ge   = !w_diff[StepW+1];
        n_rem  = w_ge ? w_diff[StepW-1:0] : {r_rem[StepW-2:0], r_quo[CountW-1]};
        n_quo  = {r_quo[CountW-2:0], w_ge};
    end

    always_comb begin
        w_pos = r_neg ? (PosW'(0) - r_quo[PosW-1:0]) : r_quo[PosW-1:0];
        w_chg = (r_kind == KIND_READ) ? (w_pos - r_last) : PosW'(0);
        w_load_out = 1'b0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_mul_cnt == MulCntW'(StepW - 1)) begin
                    n_state = ST_BOUND;
                end
            end
            ST_BOUND: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_div_cnt == DivCntW'(CountW - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= StepW'(1);
            r_min       <= -16'sd32768;
            r_max       <= 16'sd32767;
            r_wrap      <= 1'b0;
            r_enable    <= 1'b1;
            r_prev_ab   <= 2'b00;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_mul_cnt   <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_STEPS:  r_steps  <= i_cfg.data[StepW-1:0];
                    REG_MIN:    r_min    <= i_cfg.data;
                    REG_MAX:    r_max    <= i_cfg.data;
                    REG_WRAP:   r_wrap   <= i_cfg.data[0];
                    REG_ENABLE: r_enable <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_mul_cnt <= '0;
                    r_div_cnt <= '0;
                end
                ST_MUL: begin
                    r_mul_cnt <= r_mul_cnt + MulCntW'(1);
                end
                ST_BOUND: begin
                    r_count <= n_count;
                    if ((r_kind == KIND_SAMPLE) && r_enable) begin
                        r_prev_ab <= r_ab & AbMask;
                    end
                end
                ST_DIV: begin
                    r_div_cnt <= r_div_cnt + DivCntW'(1);
                end
                ST_DONE: begin
                    if (w_load_out && (r_kind == KIND_READ)) begin
                        r_last <= w_pos;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= t_kind'(i_in.kind);
            r_ab    <= {i_in.pin_b, i_in.pin_a};
            r_new   <= i_in.new_value;
            r_s     <= (r_steps == '0) ? StepW'(1) : r_steps;
            r_mbits <= (r_steps == '0) ? StepW'(1) : r_steps;
            r_lo    <= '0;
            r_hi    <= '0;
            r_ld    <= '0;
        end
        if (r_state == ST_MUL) begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_ld    <= n_ld;
            r_mbits <= {r_mbits[StepW-2:0], 1'b0};
        end
        if (r_state == ST_PREP) begin
            r_neg <= r_count[CountW-1];
            r_quo <= r_count[CountW-1] ? (CountW'(0) - r_count) : r_count;
            r_rem <= '0;
        end
        if (r_state == ST_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (w_load_out) begin
            r_out_pos <= w_pos;
            r_out_chg <= w_chg;
        end
    end

    `BQPC_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, r_state == ST_DIV,
        r_rem < r_s, "Division remainder reached the divisor.")
    `BQPC_ASSERT_NEXT(a_clamp_in_bounds, i_clk, i_rst_n,
        (r_state == ST_BOUND) && w_apply && !r_wrap && (r_lo <= r_hi),
        (r_count >= r_lo) && (r_count <= r_hi), "Clamped count left the bounds.")
    `BQPC_ASSERT_NEXT(a_count_held_in_div, i_clk, i_rst_n, r_state == ST_DIV,
        $stable(r_count) && $stable(r_last), "Count changed during division.")
endmodule
`default_nettype wire

// File: verif/bounded_quadrature_position_counter_tb.sv
// Self-checking testbench for the bounded quadrature position counter.
`timescale 1ns / 1ps
module bounded_quadrature_position_counter_tb;
    import bqpc_pkg::*;

    localparam int HoldCycles = 400;
    localparam int StallLimit = 4000;
    localparam int TailCycles = 60;
    localparam int PhaseWords = 215;
    localparam int PhaseCount = 9;
    localparam int ReportLimit = 10;
    localparam int QuadStep [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
    localparam logic [1:0] GrayUp [4] = '{2'b10, 2'b00, 2'b11, 2'b01};
    localparam logic [1:0] GrayDown [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
    localparam logic [1:0] EveryPair [16] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                                              2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
    localparam int PhaseSteps [PhaseCount] = '{4, 4, 255, 0, 3, 3, 7, 1, 255};
    localparam int PhaseMin [PhaseCount] = '{-3, -3, -32768, -32768, 5, 5, -10, 2, -32768};
    localparam int PhaseMax [PhaseCount] = '{3, 3, 32767, 32767, -5, -5, 10, 2, 32767};
    localparam int PhaseWrap [PhaseCount] = '{1, 0, 1, 0, 1, 0, 1, 0, 0};
    localparam int PhaseEnable [PhaseCount] = '{1, 1, 1, 1, 1, 1, 0, 1, 1};

    typedef struct packed {
        t_kind                  kind;
        logic                   pin_a;
        logic                   pin_b;
        logic signed [PosW-1:0] new_value;
    } encoder_word_t;

    typedef struct packed {
        logic signed [PosW-1:0] position;
        logic signed [PosW-1:0] change;
    } counter_reading_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bqpc_in_if  in_ch ();
    bqpc_out_if out_ch ();
    bqpc_cfg_if cfg_ch ();

    bounded_quadrature_position_counter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    encoder_word_t    pending_words [$];
    counter_reading_t expected_readings [$];
    encoder_word_t    word_on_bus;

    logic [StepW-1:0]         cfg_steps;
    logic signed [PosW-1:0]   cfg_min;
    logic signed [PosW-1:0]   cfg_max;
    logic                     cfg_wrap;
    logic                     cfg_enable;
    logic [1:0]               ab_prev;
    logic signed [CountW-1:0] count_raw;
    logic signed [PosW-1:0]   last_read_pos;

    logic [1:0] pin_level;
    logic       idle_enable;
    logic       hold_pending;
    int         words_queued;
    int         words_accepted;
    int         fail_count;
    int         gap_left;
    int         stall_left;
    int         quiet_cycles;

    always #4 i_clk = ~i_clk;

    function automatic counter_reading_t advance_counter(input encoder_word_t w);
        int               steps;
        int               lo;
        int               hi;
        int               cnt;
        int               quo;
        logic [1:0]       now_ab;
        logic [3:0]       idx;
        logic             bound;
        counter_reading_t r;
        steps = (cfg_steps == '0) ? 1 : int'(cfg_steps);
        lo = int'(cfg_min) * steps;
        hi = int'(cfg_max) * steps;
        cnt = int'(count_raw);
        bound = 1'b0;
        r.change = '0;
        case (w.kind)
            KIND_SAMPLE: begin
                if (cfg_enable) begin
                    now_ab = {w.pin_b, w.pin_a};
                    idx = {ab_prev, now_ab} & IndexMask;
                    ab_prev = now_ab & AbMask;
                    cnt = cnt + QuadStep[idx];
                    bound = 1'b1;
                end
            end
            KIND_LOAD: begin
                cnt = int'($signed(w.new_value)) * steps;
                bound = 1'b1;
            end
            default: begin
            end
        endcase
        if (bound) begin
            if (cnt > hi) cnt = cfg_wrap ? lo : hi;
            if (cnt < lo) cnt = cfg_wrap ? hi : lo;
        end
        count_raw = cnt[CountW-1:0];
        quo = cnt / steps;
        r.position = quo[PosW-1:0];
        if (w.kind == KIND_READ) begin
            r.change = r.position - last_read_pos;
            last_read_pos = r.position;
        end
        return r;
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 45) return 0;
        else if (r < 80) return $urandom_range(1, 8);
        else if (r < 95) return $urandom_range(9, 45);
        else return $urandom_range(46, 120);
    endfunction

    function automatic void queue_word(input t_kind k, input logic a, input logic b,
                                       input logic [PosW-1:0] v);
        encoder_word_t w;
        w.kind = k;
        w.pin_a = a;
        w.pin_b = b;
        w.new_value = v;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    function automatic void queue_sample(input logic [1:0] level);
        queue_word(KIND_SAMPLE, level[0], level[1], PosW'($urandom));
    endfunction

    function automatic void queue_random_activity();
        int              choice;
        int              len;
        logic            dir;
        logic [PosW-1:0] v;
        choice = $urandom_range(0, 99);
        if (choice < 55) begin
            len = $urandom_range(1, 24);
            dir = 1'($urandom);
            for (int i = 0; i < len; i++) begin
                pin_level = dir ? GrayUp[pin_level] : GrayDown[pin_level];
                queue_sample(pin_level);
                if ($urandom_range(0, 7) == 0) begin
                    queue_word(KIND_READ, 1'($urandom), 1'($urandom), PosW'($urandom));
                end
            end
        end else if (choice < 70) begin
            queue_word(KIND_READ, 1'($urandom), 1'($urandom), PosW'($urandom));
        end else if (choice < 82) begin
            case ($urandom_range(0, 4))
                0: v = cfg_min + PosW'($urandom_range(0, 3)) - PosW'(1);
                1: v = cfg_max - PosW'($urandom_range(0, 3)) + PosW'(1);
                2: v = PosW'($urandom_range(0, 80)) - PosW'(40);
                default: v = PosW'($urandom);
            endcase
            queue_word(KIND_LOAD, 1'($urandom), 1'($urandom), v);
        end else if (choice < 93) begin
            pin_level = 2'($urandom);
            queue_sample(pin_level);
        end else begin
            queue_word(KIND_NONE, 1'($urandom), 1'($urandom), PosW'($urandom));
        end
    endfunction

    task automatic wait_for_drain();
        do @(posedge i_clk);
        while (words_accepted != words_queued || expected_readings.size() != 0);
    endtask

    task automatic write_register(input t_reg_idx idx, input int value);
        logic [CfgDataW-1:0] data;
        data = CfgDataW'($urandom);
        case (idx)
            REG_STEPS: data[StepW-1:0] = value[StepW-1:0];
            REG_MIN, REG_MAX: data = value[CfgDataW-1:0];
            default: data[0] = value[0];
        endcase
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_STEPS: cfg_steps = data[StepW-1:0];
            REG_MIN: cfg_min = data;
            REG_MAX: cfg_max = data;
            REG_WRAP: cfg_wrap = data[0];
            REG_ENABLE: cfg_enable = data[0];
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        encoder_word_t w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_readings.push_back(advance_counter(word_on_bus));
                words_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    word_on_bus = w;
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= w.kind;
                    in_ch.pin_a <= w.pin_a;
                    in_ch.pin_b <= w.pin_b;
                    in_ch.new_value <= w.new_value;
                    gap_left = pick_idle();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        counter_reading_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ReportLimit) begin
                        $display("unexpected word: position %0d change %0d",
                                 out_ch.position, out_ch.change);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    if (out_ch.position !== want.position || out_ch.change !== want.change) begin
                        fail_count++;
                        if (fail_count <= ReportLimit) begin
                            $display("mismatch: expected position %0d change %0d, got %0d %0d",
                                     want.position, want.change,
                                     out_ch.position, out_ch.change);
                        end
                    end
                end
            end
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = HoldCycles;
            end else if (stall_left == 0 && idle_enable && $urandom_range(0, 11) == 0) begin
                stall_left = pick_idle() + 1;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_SAMPLE;
        in_ch.pin_a = 1'b0;
        in_ch.pin_b = 1'b0;
        in_ch.new_value = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_STEPS;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        cfg_steps = 8'd1;
        cfg_min = 16'sh8000;
        cfg_max = 16'sh7fff;
        cfg_wrap = 1'b0;
        cfg_enable = 1'b1;
        ab_prev = 2'b00;
        count_raw = '0;
        last_read_pos = '0;
        pin_level = 2'b00;
        idle_enable = 1'b0;
        hold_pending = 1'b0;
        words_queued = 0;
        words_accepted = 0;
        fail_count = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk through all sixteen previous/current level pairs, then hit both count limits.
        for (int i = 0; i < 16; i++) queue_sample(EveryPair[i]);
        queue_word(KIND_READ, 1'b1, 1'b0, 16'sh7fff);
        queue_word(KIND_LOAD, 1'b0, 1'b1, 16'sh7fff);
        queue_sample(2'b10);
        queue_word(KIND_READ, 1'b0, 1'b1, 16'sh8000);
        queue_word(KIND_LOAD, 1'b1, 1'b0, 16'sh8000);
        queue_sample(2'b00);
        queue_word(KIND_READ, 1'b1, 1'b1, '0);
        queue_word(KIND_NONE, 1'b1, 1'b1, 16'shffff);
        queue_word(KIND_LOAD, 1'b0, 1'b0, '0);
        queue_word(KIND_READ, 1'b0, 1'b0, 16'sh5555);
        pin_level = 2'b00;

        for (int p = 0; p < PhaseCount; p++) begin
            wait_for_drain();
            write_register(REG_STEPS, PhaseSteps[p]);
            write_register(REG_MIN, PhaseMin[p]);
            write_register(REG_MAX, PhaseMax[p]);
            write_register(REG_WRAP, PhaseWrap[p]);
            write_register(REG_ENABLE, PhaseEnable[p]);
            idle_enable = (p == 0 || p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 2) hold_pending = 1'b1;
            while (words_queued < words_accepted + PhaseWords) queue_random_activity();
        end

        wait_for_drain();
        repeat (TailCycles) @(posedge i_clk);
        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
